// ----- rtl/uvsph_pkg.sv -----
// shared types, constants and term tables for the uv sphere mesh generator
package uvsph_pkg;

    localparam int SEGMENT_LIMIT       = 255;
    localparam int ANGLE_FRACTION_BITS = 14;
    localparam int QUAD_BITS           = ANGLE_FRACTION_BITS - 2;
    localparam int TEX_FRAC            = 16;
    localparam int Q_FRAC              = 30;

    // long division lanes: quotient bits, dividend bits, remainder bits
    localparam int DIV_QW = 17;
    localparam int DIV_DW = 8 + TEX_FRAC;
    localparam int DIV_RW = 9;

    // series term datapath
    localparam int N_TERMS = 7;
    localparam int TERM_XW = 32;
    localparam int TERM_PW = 2 * TERM_XW - Q_FRAC;
    localparam int TERM_MW = TERM_PW + 1;
    localparam int TERM_SW = TERM_XW + 2;

    localparam longint unsigned PIH_Q30 = 64'd1686629713;

    // factorial factors of the sine and cosine terms and their ceil log2
    localparam int SIN_DIV [N_TERMS] = '{6, 20, 42, 72, 110, 156, 210};
    localparam int SIN_LOG [N_TERMS] = '{3, 5, 6, 7, 7, 8, 8};
    localparam int COS_DIV [N_TERMS] = '{2, 12, 30, 56, 90, 132, 182};
    localparam int COS_LOG [N_TERMS] = '{1, 4, 5, 6, 7, 8, 8};

    localparam logic FUNC_VERTEX = 1'b0;
    localparam logic FUNC_QUAD   = 1'b1;

    localparam logic [1:0] REG_LONG   = 2'd0;
    localparam logic [1:0] REG_LAT    = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    localparam logic [2:0] QUAD_LAST = 3'd5;

    typedef struct packed {
        logic [DIV_RW-1:0] rem;
        logic [DIV_QW-1:0] low;
        logic [DIV_QW-1:0] quo;
    } t_div_lane;

    typedef struct packed {
        logic [TERM_XW-1:0]        x2;
        logic [TERM_XW-1:0]        t;
        logic signed [TERM_SW-1:0] sum;
    } t_term;

    typedef struct packed {
        logic [TERM_MW-1:0] mul;
        logic [3:0]         shift;
        logic               neg;
    } t_term_ctl;

    typedef struct packed {
        logic              func;
        logic              err;
        logic [15:0]       v0;
        logic [1:0]        qt;
        logic [1:0]        qp;
        logic [DIV_QW-1:0] tex_u;
        logic [DIV_QW-1:0] tex_v;
    } t_side;

endpackage

// ----- rtl/uv_sphere_mesh_generator_top.sv -----
// top level of the uv sphere mesh generator: cell chain, series cells and output stage
//
// input channel: i_in_valid / o_in_ready carry one word (func, col, row).
// func 0 asks for grid vertex (col, row): one result word with normal, position,
// texture coordinates and linear vertex index. func 1 asks for quad (col, row):
// six result words with the triangle corner indices, the sixth flagged last.
// an out of range index gives one zeroed word with range_error and last set.
// output channel: o_out_valid / i_out_ready.
// throughput: one vertex word per cycle while the receiver is ready; a quad holds the output for its six words.
// the chain holds the 17 division cells, the 7 series term cells
// (two stages each) and the rounding and radius multiply stages behind them.
// every stage has its own valid bit, so gaps in the chain close up while the
// receiver stalls and a new word is taken as long as any stage is free.
// configuration: i_cfg_we / i_cfg_index / i_cfg_data, written while idle.
// reset (synchronous, active low) empties the chain and restores 5 longitude
// segments, 5 latitude segments and radius 1.0; no clearing pass is needed.
module uv_sphere_mesh_generator_top import uvsph_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_func,
    input  logic [7:0]         i_col,
    input  logic [7:0]         i_row,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_normal_x,
    output logic signed [15:0] o_normal_y,
    output logic signed [15:0] o_normal_z,
    output logic signed [16:0] o_pos_x,
    output logic signed [16:0] o_pos_y,
    output logic signed [16:0] o_pos_z,
    output logic [16:0]        o_tex_u,
    output logic [16:0]        o_tex_v,
    output logic [15:0]        o_vertex_index,
    output logic               o_last,
    output logic               o_range_error
);

    // stage map of the chain
    localparam int ST_DIV0  = 1;
    localparam int ST_X     = ST_DIV0 + DIV_QW;
    localparam int ST_X2    = ST_X + 1;
    localparam int ST_TERM  = ST_X2 + 1;
    localparam int ST_CLAMP = ST_TERM + 2 * N_TERMS;
    localparam int ST_PROD  = ST_CLAMP + 1;
    localparam int ST_NRM   = ST_PROD + 1;
    localparam int ST_RAD   = ST_NRM + 1;
    localparam int ST_OUT   = ST_RAD + 1;
    localparam int N_STG    = ST_OUT + 1;

    localparam logic [7:0]  LONG_RESET   = 8'd5;
    localparam logic [7:0]  LAT_RESET    = 8'd5;
    localparam logic [15:0] RADIUS_RESET = 16'd256;
    localparam logic [7:0]  LONG_MIN     = 8'd3;
    localparam logic [7:0]  LAT_MIN      = 8'd2;
    localparam logic [TERM_XW-1:0] ONE_Q30 = TERM_XW'(64'd1 << Q_FRAC);

    function automatic logic [7:0] clamp_seg(input logic [7:0] v, input logic [7:0] lo);
        logic [7:0] r;
        r = v;
        if (r < lo) r = lo;
        if (r > 8'(SEGMENT_LIMIT)) r = 8'(SEGMENT_LIMIT);
        return r;
    endfunction

    // shift right with rounding half away from zero
    function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int sh);
        logic [63:0] mag;
        mag = v[63] ? 64'(-v) : 64'(v);
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        return v[63] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic [Q_FRAC:0] clamp_unit(input logic signed [TERM_SW-1:0] v);
        logic [Q_FRAC:0] r;
        if (v < 0) r = '0;
        else if (v > $signed({2'b00, ONE_Q30})) r = ONE_Q30[Q_FRAC:0];
        else r = v[Q_FRAC:0];
        return r;
    endfunction

    // quadrant fixes swap and sign; result is {sin, cos}
    function automatic logic [63:0] quad_map(input logic [1:0] q, input logic [Q_FRAC:0] bs,
                                             input logic [Q_FRAC:0] bc);
        logic signed [31:0] s;
        logic signed [31:0] c;
        s = $signed({1'b0, bs});
        c = $signed({1'b0, bc});
        case (q)
            2'd0:    return {s, c};
            2'd1:    return {c, -s};
            2'd2:    return {-s, -c};
            default: return {-c, s};
        endcase
    endfunction

    // configuration registers
    logic [7:0]  r_long;
    logic [7:0]  r_lat;
    logic [15:0] r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long   <= LONG_RESET;
            r_lat    <= LAT_RESET;
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LONG:   r_long   <= clamp_seg(i_cfg_data[7:0], LONG_MIN);
                REG_LAT:    r_lat    <= clamp_seg(i_cfg_data[7:0], LAT_MIN);
                REG_RADIUS: r_radius <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // stage valids and load enables; a stage loads when empty or when the stage
    // behind it loads
    logic [N_STG-1:0] r_vld;
    logic [N_STG-1:0] en;
    logic             out_last;
    logic [2:0]       r_cnt;

    always_comb begin
        en[ST_OUT] = !r_vld[ST_OUT] || (i_out_ready && out_last);
        for (int s = ST_OUT - 1; s >= 0; s--) begin
            en[s] = !r_vld[s] || en[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (r_vld & ~en) | ({r_vld[N_STG-2:0], i_in_valid} & en);
        end
    end

    assign o_in_ready = en[0];

    // side data that travels with each word
    t_side r_side [N_STG];
    t_side n_side [N_STG];

    t_div_lane r_div0 [4];
    t_div_lane w_div [DIV_QW+1][4];
    logic [DIV_RW-1:0] divisor [4];
    logic [DIV_DW-1:0] dividend [4];

    always_comb begin
        // theta and u divide by the longitude count, phi by twice the latitude count
        dividend[0] = (DIV_DW'(i_col) << ANGLE_FRACTION_BITS) + DIV_DW'(r_long >> 1);
        dividend[1] = (DIV_DW'(i_col) << TEX_FRAC) + DIV_DW'(r_long >> 1);
        dividend[2] = (DIV_DW'(i_row) << ANGLE_FRACTION_BITS) + DIV_DW'(r_lat);
        dividend[3] = (DIV_DW'(i_row) << TEX_FRAC) + DIV_DW'(r_lat >> 1);
    end

    assign divisor[0] = {1'b0, r_long};
    assign divisor[1] = {1'b0, r_long};
    assign divisor[2] = {r_lat, 1'b0};
    assign divisor[3] = {1'b0, r_lat};

    logic [DIV_QW-1:0] quo_t;
    logic [DIV_QW-1:0] quo_p;

    assign quo_t = w_div[DIV_QW][0].quo;
    assign quo_p = w_div[DIV_QW][2].quo;

    always_comb begin
        n_side[0].func  = i_func;
        n_side[0].err   = (i_func == FUNC_VERTEX) ? (i_col > r_long || i_row > r_lat)
                                                  : (i_col >= r_long || i_row >= r_lat);
        n_side[0].v0    = 16'(i_row) + 16'(i_col) * (16'(r_lat) + 16'd1);
        n_side[0].qt    = '0;
        n_side[0].qp    = '0;
        n_side[0].tex_u = '0;
        n_side[0].tex_v = '0;
        for (int s = 1; s < N_STG; s++) begin
            n_side[s] = r_side[s-1];
        end
        // quadrants and texture coordinates leave the division cells here
        n_side[ST_X].qt    = quo_t[ANGLE_FRACTION_BITS-1 -: 2];
        n_side[ST_X].qp    = quo_p[ANGLE_FRACTION_BITS-1 -: 2];
        n_side[ST_X].tex_u = w_div[DIV_QW][1].quo;
        n_side[ST_X].tex_v = w_div[DIV_QW][3].quo;
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < N_STG; s++) begin
            if (en[s]) r_side[s] <= n_side[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int l = 0; l < 4; l++) begin
                r_div0[l].rem <= DIV_RW'(dividend[l][DIV_DW-1:DIV_QW]);
                r_div0[l].low <= dividend[l][DIV_QW-1:0];
                r_div0[l].quo <= '0;
            end
        end
    end

    // chain of division cells, four lanes side by side
    genvar gc, gl;
    generate
        for (gl = 0; gl < 4; gl++) begin : g_div_in
            assign w_div[0][gl] = r_div0[gl];
        end
        for (gc = 0; gc < DIV_QW; gc++) begin : g_div
            for (gl = 0; gl < 4; gl++) begin : g_lane
                uvsph_div_cell u_cell (
                    .i_clk     (i_clk),
                    .i_en      (en[ST_DIV0+gc]),
                    .i_divisor (divisor[gl]),
                    .i_lane    (w_div[gc][gl]),
                    .o_lane    (w_div[gc+1][gl])
                );
            end
        end
    endgenerate

    // turns to radians within one quadrant
    logic [63:0] prod_xt;
    logic [63:0] prod_xp;
    logic [TERM_XW-1:0] r_xt;
    logic [TERM_XW-1:0] r_xp;

    assign prod_xt = 64'(quo_t[QUAD_BITS-1:0]) * PIH_Q30;
    assign prod_xp = 64'(quo_p[QUAD_BITS-1:0]) * PIH_Q30;

    always_ff @(posedge i_clk) begin
        if (en[ST_X]) begin
            r_xt <= prod_xt[QUAD_BITS +: TERM_XW];
            r_xp <= prod_xp[QUAD_BITS +: TERM_XW];
        end
    end

    // x squared and series seeds: lanes sin theta, cos theta, sin phi, cos phi
    logic [63:0] sq_t;
    logic [63:0] sq_p;
    t_term r_trm0 [4];
    t_term w_trm [N_TERMS+1][4];

    assign sq_t = 64'(r_xt) * 64'(r_xt);
    assign sq_p = 64'(r_xp) * 64'(r_xp);

    always_ff @(posedge i_clk) begin
        if (en[ST_X2]) begin
            r_trm0[0] <= '{x2: sq_t[Q_FRAC +: TERM_XW], t: r_xt,
                           sum: $signed({2'b00, r_xt})};
            r_trm0[1] <= '{x2: sq_t[Q_FRAC +: TERM_XW], t: ONE_Q30,
                           sum: $signed({2'b00, ONE_Q30})};
            r_trm0[2] <= '{x2: sq_p[Q_FRAC +: TERM_XW], t: r_xp,
                           sum: $signed({2'b00, r_xp})};
            r_trm0[3] <= '{x2: sq_p[Q_FRAC +: TERM_XW], t: ONE_Q30,
                           sum: $signed({2'b00, ONE_Q30})};
        end
    end

    // chain of series term cells
    generate
        for (gl = 0; gl < 4; gl++) begin : g_trm_in
            assign w_trm[0][gl] = r_trm0[gl];
        end
        for (gc = 0; gc < N_TERMS; gc++) begin : g_term
            localparam longint unsigned SIN_MUL =
                ((64'd1 << (TERM_PW + SIN_LOG[gc])) + SIN_DIV[gc] - 1) / SIN_DIV[gc];
            localparam longint unsigned COS_MUL =
                ((64'd1 << (TERM_PW + COS_LOG[gc])) + COS_DIV[gc] - 1) / COS_DIV[gc];
            for (gl = 0; gl < 4; gl++) begin : g_lane
                t_term_ctl ctl;
                assign ctl.mul   = (gl % 2 == 0) ? TERM_MW'(SIN_MUL) : TERM_MW'(COS_MUL);
                assign ctl.shift = (gl % 2 == 0) ? 4'(SIN_LOG[gc]) : 4'(COS_LOG[gc]);
                // odd terms subtract
                assign ctl.neg   = (gc % 2 == 0);
                uvsph_term_cell u_cell (
                    .i_clk    (i_clk),
                    .i_en_mul (en[ST_TERM+2*gc]),
                    .i_en_div (en[ST_TERM+2*gc+1]),
                    .i_ctl    (ctl),
                    .i_term   (w_trm[gc][gl]),
                    .o_term   (w_trm[gc+1][gl])
                );
            end
        end
    endgenerate

    // clamp the sums and apply the quadrants
    logic [63:0] sc_t;
    logic [63:0] sc_p;
    logic signed [31:0] r_st;
    logic signed [31:0] r_ct;
    logic signed [31:0] r_sp;
    logic signed [31:0] r_cp;

    assign sc_t = quad_map(r_side[ST_CLAMP-1].qt, clamp_unit(w_trm[N_TERMS][0].sum),
                           clamp_unit(w_trm[N_TERMS][1].sum));
    assign sc_p = quad_map(r_side[ST_CLAMP-1].qp, clamp_unit(w_trm[N_TERMS][2].sum),
                           clamp_unit(w_trm[N_TERMS][3].sum));

    always_ff @(posedge i_clk) begin
        if (en[ST_CLAMP]) begin
            r_st <= $signed(sc_t[63:32]);
            r_ct <= $signed(sc_t[31:0]);
            r_sp <= $signed(sc_p[63:32]);
            r_cp <= $signed(sc_p[31:0]);
        end
    end

    // normal products
    logic signed [63:0] r_p0;
    logic signed [63:0] r_p2;
    logic signed [31:0] r_n1a;

    always_ff @(posedge i_clk) begin
        if (en[ST_PROD]) begin
            r_p0  <= 64'(r_ct) * 64'(r_sp);
            r_p2  <= 64'(r_st) * 64'(r_sp);
            r_n1a <= r_cp;
        end
    end

    logic signed [63:0] rn0;
    logic signed [63:0] rn2;
    logic signed [31:0] r_n0;
    logic signed [31:0] r_n1;
    logic signed [31:0] r_n2;

    assign rn0 = rnd(r_p0, Q_FRAC);
    assign rn2 = rnd(r_p2, Q_FRAC);

    always_ff @(posedge i_clk) begin
        if (en[ST_NRM]) begin
            r_n0 <= rn0[31:0];
            r_n1 <= r_n1a;
            r_n2 <= rn2[31:0];
        end
    end

    // radius products and normal rounding
    logic signed [16:0] rad_s;
    logic signed [63:0] nr0;
    logic signed [63:0] nr1;
    logic signed [63:0] nr2;
    logic signed [48:0] r_q0;
    logic signed [48:0] r_q1;
    logic signed [48:0] r_q2;
    logic signed [15:0] r_nx;
    logic signed [15:0] r_ny;
    logic signed [15:0] r_nz;

    assign rad_s = $signed({1'b0, r_radius});
    assign nr0   = rnd(64'(r_n0), 16);
    assign nr1   = rnd(64'(r_n1), 16);
    assign nr2   = rnd(64'(r_n2), 16);

    always_ff @(posedge i_clk) begin
        if (en[ST_RAD]) begin
            r_q0 <= 49'(r_n0) * 49'(rad_s);
            r_q1 <= 49'(r_n1) * 49'(rad_s);
            r_q2 <= 49'(r_n2) * 49'(rad_s);
            r_nx <= nr0[15:0];
            r_ny <= nr1[15:0];
            r_nz <= nr2[15:0];
        end
    end

    // output register
    logic               keep;
    logic signed [63:0] pr0;
    logic signed [63:0] pr1;
    logic signed [63:0] pr2;
    logic signed [15:0] r_o_nx;
    logic signed [15:0] r_o_ny;
    logic signed [15:0] r_o_nz;
    logic signed [16:0] r_o_px;
    logic signed [16:0] r_o_py;
    logic signed [16:0] r_o_pz;
    logic [16:0]        r_o_u;
    logic [16:0]        r_o_v;
    logic [15:0]        r_o_v0;
    logic [15:0]        r_o_v1;
    logic               r_o_func;
    logic               r_o_err;

    assign keep = r_side[ST_RAD].func == FUNC_VERTEX && !r_side[ST_RAD].err;
    assign pr0  = rnd(64'(r_q0), Q_FRAC);
    assign pr1  = rnd(64'(r_q1), Q_FRAC);
    assign pr2  = rnd(64'(r_q2), Q_FRAC);

    always_ff @(posedge i_clk) begin
        if (en[ST_OUT]) begin
            r_o_nx   <= keep ? r_nx : '0;
            r_o_ny   <= keep ? r_ny : '0;
            r_o_nz   <= keep ? r_nz : '0;
            r_o_px   <= keep ? pr0[16:0] : '0;
            r_o_py   <= keep ? pr1[16:0] : '0;
            r_o_pz   <= keep ? pr2[16:0] : '0;
            r_o_u    <= keep ? r_side[ST_RAD].tex_u : '0;
            r_o_v    <= keep ? r_side[ST_RAD].tex_v : '0;
            r_o_v0   <= r_side[ST_RAD].err ? '0 : r_side[ST_RAD].v0;
            r_o_v1   <= r_side[ST_RAD].v0 + 16'(r_lat) + 16'd1;
            r_o_func <= r_side[ST_RAD].func;
            r_o_err  <= r_side[ST_RAD].err;
        end
    end

    // word counter for the six corners of a quad
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (en[ST_OUT]) begin
            r_cnt <= '0;
        end else if (i_out_ready && r_vld[ST_OUT]) begin
            r_cnt <= r_cnt + 3'd1;
        end
    end

    assign out_last = r_o_err || r_o_func == FUNC_VERTEX || r_cnt == QUAD_LAST;

    // corners v0 v1 v1+1 v0 v1+1 v0+1
    always_comb begin
        case (r_cnt)
            3'd1:    o_vertex_index = r_o_v1;
            3'd2:    o_vertex_index = r_o_v1 + 16'd1;
            3'd4:    o_vertex_index = r_o_v1 + 16'd1;
            3'd5:    o_vertex_index = r_o_v0 + 16'd1;
            default: o_vertex_index = r_o_v0;
        endcase
    end

    assign o_out_valid   = r_vld[ST_OUT];
    assign o_normal_x    = r_o_nx;
    assign o_normal_y    = r_o_ny;
    assign o_normal_z    = r_o_nz;
    assign o_pos_x       = r_o_px;
    assign o_pos_y       = r_o_py;
    assign o_pos_z       = r_o_pz;
    assign o_tex_u       = r_o_u;
    assign o_tex_v       = r_o_v;
    assign o_last        = out_last;
    assign o_range_error = r_o_err;

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QUAD_LAST)
        else $error("quad word counter past the last corner");

    a_single_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_o_err || r_o_func == FUNC_VERTEX)) |-> r_cnt == 3'd0)
        else $error("counter moved on a single word result");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last) |=>
        (o_out_valid && r_cnt == $past(r_cnt) + 3'd1))
        else $error("quad corner sequence broken");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_range_error) |->
        (o_last && o_vertex_index == 16'd0 && o_normal_y == 16'sd0 && o_tex_u == 17'd0))
        else $error("range error word not zeroed");
`endif

endmodule

// ----- rtl/uvsph_div_cell.sv -----
// one restoring long division step, one quotient bit per cell
module uvsph_div_cell import uvsph_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [DIV_RW-1:0] i_divisor,
    input  t_div_lane         i_lane,
    output t_div_lane         o_lane
);

    logic [DIV_RW:0] trial;
    logic            ge;
    t_div_lane       r_lane;

    assign trial = {i_lane.rem, i_lane.low[DIV_QW-1]};
    assign ge    = trial >= {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane.rem <= ge ? DIV_RW'(trial - {1'b0, i_divisor}) : trial[DIV_RW-1:0];
            r_lane.low <= {i_lane.low[DIV_QW-2:0], 1'b0};
            r_lane.quo <= {i_lane.quo[DIV_QW-2:0], ge};
        end
    end

    assign o_lane = r_lane;

endmodule

// ----- rtl/uvsph_term_cell.sv -----
// one maclaurin series term: multiply by x squared, divide by factorial factor, accumulate
module uvsph_term_cell import uvsph_pkg::*; (
    input  logic      i_clk,
    input  logic      i_en_mul,
    input  logic      i_en_div,
    input  t_term_ctl i_ctl,
    input  t_term     i_term,
    output t_term     o_term
);

    logic [2*TERM_XW-1:0]       full;
    logic [TERM_PW+TERM_MW-1:0] qfull;
    logic [TERM_XW-1:0]         quo;
    logic signed [TERM_SW-1:0]  n_sum;

    logic [TERM_PW-1:0]        r_prod;
    logic [TERM_XW-1:0]        r_x2;
    logic signed [TERM_SW-1:0] r_sum;
    t_term                     r_out;

    assign full = (2*TERM_XW)'(i_term.t) * (2*TERM_XW)'(i_term.x2);

    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_prod <= full[Q_FRAC +: TERM_PW];
            r_x2   <= i_term.x2;
            r_sum  <= i_term.sum;
        end
    end

    // exact floor division by multiply with rounded-up reciprocal
    assign qfull = (TERM_PW+TERM_MW)'(r_prod) * (TERM_PW+TERM_MW)'(i_ctl.mul);
    assign quo   = TERM_XW'(qfull >> (TERM_PW + int'(i_ctl.shift)));
    assign n_sum = i_ctl.neg ? r_sum - $signed({2'b00, quo}) : r_sum + $signed({2'b00, quo});

    always_ff @(posedge i_clk) begin
        if (i_en_div) begin
            r_out.x2  <= r_x2;
            r_out.t   <= quo;
            r_out.sum <= n_sum;
        end
    end

    assign o_term = r_out;

endmodule
